// ----- src/cdq_pkg.sv -----
package cdq_pkg;

    // Command codes carried on the command port
    typedef enum logic [1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_REAR  = 2'd1,
        CMD_REM_FRONT = 2'd2,
        CMD_REM_REAR  = 2'd3
    } cmd_t;

    // Status codes returned with every result
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OCC_W  = 4;

    // Per-cycle shift controls broadcast to every cell, already qualified
    typedef struct packed {
        logic ins_front;
        logic ins_rear;
        logic rem_front;
    } cell_ctl_t;

endpackage

// ----- src/cdq_cell.sv -----
module cdq_cell #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned INDEX = 0
) (
    input  logic                          clk,
    input  cdq_pkg::cell_ctl_t            ctl,
    input  logic [$clog2(DEPTH+1)-1:0]    count,
    input  logic [cdq_pkg::WORD_W-1:0]    value,
    input  logic [cdq_pkg::WORD_W-1:0]    left_word,
    input  logic [cdq_pkg::WORD_W-1:0]    right_word,
    output logic [cdq_pkg::WORD_W-1:0]    word,
    output logic [cdq_pkg::WORD_W-1:0]    rear_word
);
    import cdq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] IDX      = CW'(INDEX);
    localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    // Shift toward the rear on front insert, toward the front on front removal,
    // load at the first free slot on rear insert
    always_comb
    begin
        word_next = word_reg;
        if (ctl.ins_front)
        begin
            word_next = left_word;
        end
        else if (ctl.ins_rear && (count == IDX))
        begin
            word_next = value;
        end
        else if (ctl.rem_front)
        begin
            word_next = right_word;
        end
    end

    // Payload storage, no reset needed
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

    // Only the current rear cell drives its word into the rear OR bus
    assign rear_word = (count == IDX_NEXT) ? word_reg : '0;

endmodule

// ----- src/cdq_ctrl.sv -----
module cdq_ctrl #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    command,
    input  logic [cdq_pkg::WORD_W-1:0]    front_word,
    input  logic [cdq_pkg::WORD_W-1:0]    rear_word,
    output cdq_pkg::cell_ctl_t            ctl,
    output logic [$clog2(DEPTH+1)-1:0]    count,
    output logic                          done,
    output logic [cdq_pkg::WORD_W-1:0]    data,
    output logic [1:0]                    status,
    output logic [cdq_pkg::OCC_W-1:0]     occupancy
);
    import cdq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              done_reg;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [OCC_W-1:0]  occ_reg;

    logic is_insert;
    logic is_full;
    logic is_empty;
    logic op_ok;

    // Decode the transaction and refuse on full or empty
    assign is_insert = (command == CMD_INS_FRONT) || (command == CMD_INS_REAR);
    assign is_full   = (count_reg == FULL_COUNT);
    assign is_empty  = (count_reg == '0);
    assign op_ok     = start && (is_insert ? !is_full : !is_empty);

    assign ctl.ins_front = op_ok && (command == CMD_INS_FRONT);
    assign ctl.ins_rear  = op_ok && (command == CMD_INS_REAR);
    assign ctl.rem_front = op_ok && (command == CMD_REM_FRONT);

    // Occupancy update and result selection
    always_comb
    begin
        count_next  = count_reg;
        data_next   = '0;
        status_next = ST_OK;
        if (start)
        begin
            if (is_insert)
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    data_next  = (command == CMD_REM_FRONT) ? front_word : rear_word;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign count     = count_reg;
    assign done      = done_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

    // Occupancy never exceeds the store depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("occupancy above depth");

    // A refused insert leaves the count at full
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (start && is_insert && is_full) |=> (count_reg == FULL_COUNT))
        else $error("refused insert changed occupancy");

    // A refused removal leaves the deque empty and reports empty
    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !is_insert && is_empty) |=> (count_reg == '0 && status_reg == ST_EMPTY))
        else $error("refused removal misbehaved");

    // Count moves by at most one per cycle; this checks that it stays unchanged when no transaction was started
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(start) |-> $stable(count_reg))
        else $error("occupancy changed without a transaction");

endmodule

// ----- src/circular_deque_core.sv -----
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+----------------------------------
// command   | start, busy, command, value    | taken when start high, busy low
// result    | done, data, status, occupancy  | one-cycle strobe on done
//
// One transaction is taken per cycle; busy stays low. The result appears on
// the cycle after the transaction is taken, with done high for that cycle.
// The words live in a row of DEPTH cells, front at cell 0; a front insert or
// front removal shifts every cell in the same cycle; a rear insert loads one cell.
// Reset clears the occupancy count and done only; cell contents are left as they are.
// The receiver cannot stall: every result is shown exactly once.
module circular_deque_core #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic [cdq_pkg::WORD_W-1:0]    value,
    output logic                          done,
    output logic [cdq_pkg::WORD_W-1:0]    data,
    output logic [1:0]                    status,
    output logic [cdq_pkg::OCC_W-1:0]     occupancy
);
    import cdq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    cell_ctl_t         ctl;
    logic [CW-1:0]     count;
    logic [WORD_W-1:0] cell_word [DEPTH];
    logic [WORD_W-1:0] cell_rear [DEPTH];
    logic [WORD_W-1:0] rear_word;

    assign busy = 1'b0;

    // Control: occupancy count, refusal checks and result registers
    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .front_word (cell_word[0]),
        .rear_word  (rear_word),
        .ctl        (ctl),
        .count      (count),
        .done       (done),
        .data       (data),
        .status     (status),
        .occupancy  (occupancy)
    );

    // Row of cells fed by neighbors; value enters left of cell 0, zero right of the last
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = value;
        end
        else
        begin : g_mid_l
            assign left_w = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_word[i+1];
        end

        cdq_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count),
            .value      (value),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i]),
            .rear_word  (cell_rear[i])
        );
    end

    // Rear word bus: at most one cell, the rear one, drives its word; the others give zero
    always_comb
    begin
        rear_word = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rear_word = rear_word | cell_rear[k];
        end
    end

endmodule
